@@ hdl/cov_pkg.sv @@
// shared types, register codes and pixel arithmetic for the cursor overlay
package cov_pkg;

    localparam int DEF_MAX_CURSOR_SIDE = 64;
    localparam int DEF_COORD_BITS      = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int POS_W      = 13;
    localparam int SIZE_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOTSPOT_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOTSPOT_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HEIGHT = 3'd6;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_COMPOSITE = 1'b1;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;
    localparam logic [15:0] ROUND_HALF   = 16'd127;

    // blue in the lowest byte
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pix;

    typedef struct packed {
        logic                     enable;
        logic signed [POS_W-1:0]  mouse_x;
        logic signed [POS_W-1:0]  mouse_y;
        logic signed [POS_W-1:0]  hotspot_x;
        logic signed [POS_W-1:0]  hotspot_y;
        logic [SIZE_W-1:0]        cursor_width;
        logic [SIZE_W-1:0]        cursor_height;
    } t_cfg;

    // exact floor(v / 255) for v below 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] s, input logic [7:0] q);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, q};
        return t[8] ? 8'hFF : t[7:0];
    endfunction

endpackage

@@ hdl/cov_locate.sv @@
// cursor rectangle test and store address for one request
module cov_locate import cov_pkg::*; #(
    parameter int MAX_CURSOR_SIDE = DEF_MAX_CURSOR_SIDE,
    parameter int COORD_BITS      = DEF_COORD_BITS,
    localparam int AW = (MAX_CURSOR_SIDE > 1) ?
                        $clog2(MAX_CURSOR_SIDE * MAX_CURSOR_SIDE) : 1
) (
    input  t_cfg                  i_cfg,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    output logic                  o_hit,
    output logic                  o_in_store,
    output logic [AW-1:0]         o_addr
);

    localparam int XW = (MAX_CURSOR_SIDE > 1) ? $clog2(MAX_CURSOR_SIDE) : 1;
    localparam int DW = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;
    localparam int EW = 10;

    logic signed [DW-1:0] cx, cy, dx, dy;
    logic [EW-1:0]        side, ew, eh;
    logic [XW-1:0]        ax, ay;

    assign cx = DW'(i_cfg.mouse_x) - DW'(i_cfg.hotspot_x);
    assign cy = DW'(i_cfg.mouse_y) - DW'(i_cfg.hotspot_y);
    assign dx = $signed({{(DW-COORD_BITS){1'b0}}, i_px}) - cx;
    assign dy = $signed({{(DW-COORD_BITS){1'b0}}, i_py}) - cy;

    // oversized cursor clamps to the store side
    assign side = EW'(MAX_CURSOR_SIDE);
    assign ew = ({{(EW-SIZE_W){1'b0}}, i_cfg.cursor_width} > side) ?
                side : {{(EW-SIZE_W){1'b0}}, i_cfg.cursor_width};
    assign eh = ({{(EW-SIZE_W){1'b0}}, i_cfg.cursor_height} > side) ?
                side : {{(EW-SIZE_W){1'b0}}, i_cfg.cursor_height};

    assign o_hit = i_cfg.enable && (ew != '0) && (eh != '0) &&
                   !dx[DW-1] && !dy[DW-1] &&
                   (dx < $signed({{(DW-EW){1'b0}}, ew})) &&
                   (dy < $signed({{(DW-EW){1'b0}}, eh}));

    assign o_in_store = ({{(32-COORD_BITS){1'b0}}, i_px} < 32'(MAX_CURSOR_SIDE)) &&
                        ({{(32-COORD_BITS){1'b0}}, i_py} < 32'(MAX_CURSOR_SIDE));

    assign ax = (i_op == OP_LOAD) ? i_px[XW-1:0] : dx[XW-1:0];
    assign ay = (i_op == OP_LOAD) ? i_py[XW-1:0] : dy[XW-1:0];

    assign o_addr = AW'(ay) * AW'(MAX_CURSOR_SIDE) + AW'(ax);

endmodule

@@ hdl/cov_store.sv @@
// cursor image memory, one write and one registered read port
module cov_store import cov_pkg::*; #(
    parameter int MAX_CURSOR_SIDE = DEF_MAX_CURSOR_SIDE,
    localparam int DEPTH = MAX_CURSOR_SIDE * MAX_CURSOR_SIDE,
    localparam int AW = (MAX_CURSOR_SIDE > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pix          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_pix          o_rdata
);

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cursor_overlay_alpha_blend.sv @@
// top level: cursor overlay with stored premultiplied image and source-over blend
// a composite request passes stage 1, stage 2 and the output register on its way to the master side
// throughput: one request per cycle while not stalled, loads and composites freely mixed
// the whole pipeline stalls only while the output register holds an untaken result
// reset clears the configuration and the pipeline valid flags; the cursor memory is not cleared
// and an entry reads undefined until a load writes it
module cursor_overlay_alpha_blend import cov_pkg::*; #(
    parameter int MAX_CURSOR_SIDE = DEF_MAX_CURSOR_SIDE,
    parameter int COORD_BITS      = DEF_COORD_BITS,
    localparam int AW = (MAX_CURSOR_SIDE > 1) ?
                        $clog2(MAX_CURSOR_SIDE * MAX_CURSOR_SIDE) : 1,
    localparam int IN_W = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,  // pixel_x, pixel_y, chan_0, chan_1, chan_2, chan_3
    input  logic                  s_axis_tuser,  // operation

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // out_blue, out_green, out_red, out_alpha
    output logic                  m_axis_tuser   // under_cursor
);

    t_cfg                  r_cfg;
    logic                  w_adv, w_acc;
    logic [COORD_BITS-1:0] w_px, w_py;
    t_pix                  w_chan;
    logic                  w_loc_hit, w_loc_in_store;
    logic [AW-1:0]         w_loc_addr;

    // stage 1
    logic                  r1_valid, r1_op, r1_hit;
    logic [AW-1:0]         r1_addr;
    t_pix                  r1_chan;
    t_pix                  w_rdata, w_src;
    logic                  w_fwd2, w_fwd_last;
    logic [7:0]            w_k, w_mb, w_mg, w_mr, w_ma;
    logic [15:0]           w_pb, w_pg, w_pr, w_pa;

    // stage 2
    logic                  r2_valid, r2_op, r2_hit;
    logic [AW-1:0]         r2_addr;
    logic [15:0]           r2_pb, r2_pg, r2_pr, r2_pa;
    t_pix                  r2_src, r2_dst;
    t_pix                  w_wdata, w_res;
    logic                  w_we;

    // last write, for forwarding
    logic                  r_lw_valid;
    logic [AW-1:0]         r_lw_addr;
    t_pix                  r_lw_data;

    // output register
    logic                  r_out_valid, r_out_under;
    t_pix                  r_out_pix;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:        r_cfg.enable        <= i_cfg_data[0];
                CFG_MOUSE_X:       r_cfg.mouse_x       <= $signed(i_cfg_data);
                CFG_MOUSE_Y:       r_cfg.mouse_y       <= $signed(i_cfg_data);
                CFG_HOTSPOT_X:     r_cfg.hotspot_x     <= $signed(i_cfg_data);
                CFG_HOTSPOT_Y:     r_cfg.hotspot_y     <= $signed(i_cfg_data);
                CFG_CURSOR_WIDTH:  r_cfg.cursor_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_CURSOR_HEIGHT: r_cfg.cursor_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // request side
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;

    assign w_px   = s_axis_tdata[COORD_BITS-1:0];
    assign w_py   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_chan = s_axis_tdata[2*COORD_BITS+31:2*COORD_BITS];

    cov_locate #(
        .MAX_CURSOR_SIDE (MAX_CURSOR_SIDE),
        .COORD_BITS      (COORD_BITS)
    ) u_locate (
        .i_cfg      (r_cfg),
        .i_op       (s_axis_tuser),
        .i_px       (w_px),
        .i_py       (w_py),
        .o_hit      (w_loc_hit),
        .o_in_store (w_loc_in_store),
        .o_addr     (w_loc_addr)
    );

    cov_store #(
        .MAX_CURSOR_SIDE (MAX_CURSOR_SIDE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r2_addr),
        .i_wdata (w_wdata),
        .i_re    (w_adv),
        .i_raddr (w_loc_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op   <= s_axis_tuser;
            r1_hit  <= (s_axis_tuser == OP_LOAD) ? w_loc_in_store : w_loc_hit;
            r1_addr <= w_loc_addr;
            r1_chan <= w_chan;
        end
    end

    // forward loads not yet in the memory at read time, newest first
    assign w_fwd2     = r2_valid && (r2_op == OP_LOAD) && r2_hit && (r2_addr == r1_addr);
    assign w_fwd_last = r_lw_valid && (r_lw_addr == r1_addr);
    assign w_src      = w_fwd2 ? w_wdata : (w_fwd_last ? r_lw_data : w_rdata);

    // load: colors times straight alpha, red and blue swap places
    // composite: destination times inverse source alpha
    always_comb begin
        if (r1_op == OP_LOAD) begin
            w_k  = r1_chan.a;
            w_mb = r1_chan.r;
            w_mg = r1_chan.g;
            w_mr = r1_chan.b;
            w_ma = r1_chan.a;
        end else begin
            w_k  = ALPHA_OPAQUE - w_src.a;
            w_mb = r1_chan.b;
            w_mg = r1_chan.g;
            w_mr = r1_chan.r;
            w_ma = r1_chan.a;
        end
    end

    assign w_pb = 16'(w_mb) * 16'(w_k) + ROUND_HALF;
    assign w_pg = 16'(w_mg) * 16'(w_k) + ROUND_HALF;
    assign w_pr = 16'(w_mr) * 16'(w_k) + ROUND_HALF;
    assign w_pa = 16'(w_ma) * 16'(w_k) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_op   <= r1_op;
            r2_hit  <= r1_hit;
            r2_addr <= r1_addr;
            r2_pb   <= w_pb;
            r2_pg   <= w_pg;
            r2_pr   <= w_pr;
            r2_pa   <= w_pa;
            r2_src  <= w_src;
            r2_dst  <= r1_chan;
        end
    end

    // premultiplied word written back
    assign w_wdata.b = div255(r2_pb);
    assign w_wdata.g = div255(r2_pg);
    assign w_wdata.r = div255(r2_pr);
    assign w_wdata.a = r2_dst.a;
    assign w_we      = w_adv && r2_valid && (r2_op == OP_LOAD) && r2_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (w_adv) begin
            r_lw_valid <= r2_valid && (r2_op == OP_LOAD) && r2_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lw_addr <= r2_addr;
            r_lw_data <= w_wdata;
        end
    end

    // source-over blend
    always_comb begin
        if (!r2_hit) begin
            w_res = r2_dst;
        end else if (r2_src.a == ALPHA_OPAQUE) begin
            w_res   = r2_src;
            w_res.a = ALPHA_OPAQUE;
        end else if (r2_src.a == ALPHA_CLEAR) begin
            w_res = r2_dst;
        end else begin
            w_res.b = sat_add(r2_src.b, div255(r2_pb));
            w_res.g = sat_add(r2_src.g, div255(r2_pg));
            w_res.r = sat_add(r2_src.r, div255(r2_pr));
            w_res.a = sat_add(r2_src.a, div255(r2_pa));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r2_valid && (r2_op == OP_COMPOSITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pix   <= w_res;
            r_out_under <= r2_hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tuser  = r_out_under;

    // checks
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r2_valid && (r2_op == OP_LOAD)) |=> !m_axis_tvalid)
        else $error("load produced a result");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(r1_valid) && $stable(r2_valid) && $stable(r2_addr)))
        else $error("pipeline moved during stall");

    a_hit_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_loc_hit |-> r_cfg.enable)
        else $error("cursor hit while disabled");

    a_write_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_lw_valid && (r_lw_addr == $past(r2_addr))))
        else $error("write not recorded for forwarding");

endmodule
